### src/tmpe_pkg.sv
package tmpe_pkg;

  localparam int PixelBitsDef   = 12;
  localparam int CordicStepsDef = 16;
  localparam int ArcCount       = 24;

  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;

  localparam logic signed [17:0] SatHi = 18'sd131071;
  localparam logic signed [17:0] SatLo = -18'sd131072;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_A_X   = 3'd0,
    REG_A_Y   = 3'd1,
    REG_B_X   = 3'd2,
    REG_B_Y   = 3'd3,
    REG_TOP_X = 3'd4,
    REG_TOP_Y = 3'd5
  } reg_idx_t;

  // arctangent table, binary angle of atan(2^-i)
  function automatic logic [31:0] arc_tab(input int idx);
    logic [31:0] r;
    begin
      unique case (idx)
        0: r = 32'd536870912;
        1: r = 32'd316933406;
        2: r = 32'd167458907;
        3: r = 32'd85004756;
        4: r = 32'd42667331;
        5: r = 32'd21354465;
        6: r = 32'd10679838;
        7: r = 32'd5340245;
        8: r = 32'd2670163;
        9: r = 32'd1335087;
        10: r = 32'd667544;
        11: r = 32'd333772;
        12: r = 32'd166886;
        13: r = 32'd83443;
        14: r = 32'd41722;
        15: r = 32'd20861;
        16: r = 32'd10430;
        17: r = 32'd5215;
        18: r = 32'd2608;
        19: r = 32'd1304;
        20: r = 32'd652;
        21: r = 32'd326;
        22: r = 32'd163;
        default: r = 32'd81;
      endcase
      return r;
    end
  endfunction

endpackage

### src/tmpe_datapath.sv
// pipelined datapath: setup, three vectoring cordic chains, a rotation chain, scale, divide, output
module tmpe_datapath import tmpe_pkg::*; #(
  parameter int PIXEL_BITS   = PixelBitsDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic [PIXEL_BITS-1:0]        x1_i,
  input  logic [PIXEL_BITS-1:0]        y1_i,
  input  logic [PIXEL_BITS-1:0]        x2_i,
  input  logic [PIXEL_BITS-1:0]        y2_i,
  input  logic [PIXEL_BITS-1:0]        x3_i,
  input  logic [PIXEL_BITS-1:0]        y3_i,
  input  logic signed [19:0]           lay_i [6],
  output logic                         vld_o,
  output logic signed [17:0]           cx_o,
  output logic signed [17:0]           cy_o,
  output logic [15:0]                  hd_o,
  output logic                         err_o
);

  localparam int N   = (CORDIC_STEPS > ArcCount) ? ArcCount : CORDIC_STEPS;
  localparam int PB  = PIXEL_BITS;
  // vectoring width: pixel differences (PB+2 bits) times 2^16, plus gain headroom
  localparam int VW  = PB + 3 + 16 + 3;
  // layout vectors: 22 bits times 2^16
  localparam int MW  = 22 + 16 + 3;
  // rotation: 22-bit sums times 2^8
  localparam int RW  = 22 + 8 + 3;
  localparam int DL  = 64;            // not used; the dividers have AW stages (quotient bits)
  localparam int SW  = PB + 7;        // 16*pixel sum width

  // ---------------- stage 0: setup ----------------
  logic               s0_v_r;
  logic signed [VW-1:0] b_x_r, b_y_r, p_x_r, p_y_r;
  logic signed [MW-1:0] m_x_r, m_y_r;
  logic signed [RW-1:0] r_x_r, r_y_r;
  logic [31:0]        b_z_r, p_z_r, m_z_r, r_z_r;
  logic               b_zero_r, p_zero_r, m_zero_r, side_pos_r, err0_r;
  logic [SW-1:0]      sx_r, sy_r;

  logic signed [PB+1:0] dx, dy, ex, ey, px, py;
  logic signed [2*PB+4:0] side;
  logic signed [22:0] mx2, my2, rvx, rvy;
  logic signed [VW-1:0] bxs, bys, pxs, pys;
  logic signed [MW-1:0] mxs, mys;
  logic signed [RW-1:0] rxs, rys;
  logic signed [32:0] rz;

  always_comb begin
    dx  = $signed({2'b0, x3_i}) - $signed({2'b0, x2_i});
    dy  = $signed({2'b0, y3_i}) - $signed({2'b0, y2_i});
    ex  = $signed({2'b0, x1_i}) - $signed({2'b0, x2_i});
    ey  = $signed({2'b0, y1_i}) - $signed({2'b0, y2_i});
    side = (PB+PB+5)'(dx * ey) - (PB+PB+5)'(dy * ex);
    px  = $signed({1'b0, x1_i, 1'b0}) - $signed({2'b0, x2_i}) - $signed({2'b0, x3_i});
    py  = $signed({1'b0, y1_i, 1'b0}) - $signed({2'b0, y2_i}) - $signed({2'b0, y3_i});
    mx2 = 23'(2 * lay_i[REG_TOP_X]) - 23'(lay_i[REG_A_X]) - 23'(lay_i[REG_B_X]);
    my2 = 23'(2 * lay_i[REG_TOP_Y]) - 23'(lay_i[REG_A_Y]) - 23'(lay_i[REG_B_Y]);
    rvx = 23'(lay_i[REG_A_X]) + 23'(lay_i[REG_B_X]) + 23'(lay_i[REG_TOP_X]);
    rvy = -(23'(lay_i[REG_A_Y]) + 23'(lay_i[REG_B_Y]) + 23'(lay_i[REG_TOP_Y]));
    bxs = VW'(dx) <<< 16; bys = VW'(dy) <<< 16;
    pxs = VW'(px) <<< 16; pys = VW'(py) <<< 16;
    mxs = MW'(mx2) <<< 16; mys = MW'(my2) <<< 16;
    rxs = RW'(rvx) <<< 8;  rys = RW'(rvy) <<< 8;
    rz  = 33'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= vld_i;
    end
    // pre-rotate into the right half plane
    b_x_r <= (dx < 0) ? -bxs : bxs;
    b_y_r <= (dx < 0) ? -bys : bys;
    b_z_r <= (dx < 0) ? HalfTurn : 32'd0;
    p_x_r <= (px < 0) ? -pxs : pxs;
    p_y_r <= (px < 0) ? -pys : pys;
    p_z_r <= 32'd0;
    m_x_r <= (mx2 < 0) ? -mxs : mxs;
    m_y_r <= (mx2 < 0) ? -mys : mys;
    m_z_r <= 32'd0;
    r_x_r <= rxs;
    r_y_r <= rys;
    r_z_r <= rz[31:0];
    b_zero_r   <= (dx == 0) && (dy == 0);
    p_zero_r   <= (px == 0) && (py == 0);
    m_zero_r   <= (mx2 == 0) && (my2 == 0);
    err0_r     <= (mx2 == 0) && (my2 == 0);
    side_pos_r <= side > 0;
    sx_r <= SW'({x1_i, 4'b0}) + SW'({x2_i, 4'b0}) + SW'({x3_i, 4'b0});
    sy_r <= SW'({y1_i, 4'b0}) + SW'({y2_i, 4'b0}) + SW'({y3_i, 4'b0});
  end

  // ---------------- vectoring chains (base and both distances) ----------------
  logic signed [VW-1:0] bx_r [N+1], by_r [N+1], qx_r [N+1], qy_r [N+1];
  logic signed [MW-1:0] mx_r [N+1], my_r [N+1];
  logic [31:0]          bz_r [N+1];
  logic                 v1_r [N+1], bzr_r [N+1], pzr_r [N+1], mzr_r [N+1];
  logic                 sp_r [N+1], er_r [N+1];
  logic [SW-1:0]        sx1_r [N+1], sy1_r [N+1];
  logic signed [RW-1:0] rx0_r [N+1], ry0_r [N+1];

  always_comb begin
    bx_r[0] = b_x_r; by_r[0] = b_y_r; bz_r[0] = b_z_r;
    qx_r[0] = p_x_r; qy_r[0] = p_y_r;
    mx_r[0] = m_x_r; my_r[0] = m_y_r;
    v1_r[0] = s0_v_r; bzr_r[0] = b_zero_r; pzr_r[0] = p_zero_r; mzr_r[0] = m_zero_r;
    sp_r[0] = side_pos_r; er_r[0] = err0_r; sx1_r[0] = sx_r; sy1_r[0] = sy_r;
    rx0_r[0] = r_x_r; ry0_r[0] = r_y_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[i+1] <= 1'b0;
      end else begin
        v1_r[i+1] <= v1_r[i];
      end
      if (by_r[i] > 0) begin
        bx_r[i+1] <= bx_r[i] + (by_r[i] >>> i);
        by_r[i+1] <= by_r[i] - (bx_r[i] >>> i);
        bz_r[i+1] <= bz_r[i] + arc_tab(i);
      end else begin
        bx_r[i+1] <= bx_r[i] - (by_r[i] >>> i);
        by_r[i+1] <= by_r[i] + (bx_r[i] >>> i);
        bz_r[i+1] <= bz_r[i] - arc_tab(i);
      end
      if (qy_r[i] > 0) begin
        qx_r[i+1] <= qx_r[i] + (qy_r[i] >>> i);
        qy_r[i+1] <= qy_r[i] - (qx_r[i] >>> i);
      end else begin
        qx_r[i+1] <= qx_r[i] - (qy_r[i] >>> i);
        qy_r[i+1] <= qy_r[i] + (qx_r[i] >>> i);
      end
      if (my_r[i] > 0) begin
        mx_r[i+1] <= mx_r[i] + (my_r[i] >>> i);
        my_r[i+1] <= my_r[i] - (mx_r[i] >>> i);
      end else begin
        mx_r[i+1] <= mx_r[i] - (my_r[i] >>> i);
        my_r[i+1] <= my_r[i] + (mx_r[i] >>> i);
      end
      bzr_r[i+1] <= bzr_r[i]; pzr_r[i+1] <= pzr_r[i]; mzr_r[i+1] <= mzr_r[i];
      sp_r[i+1] <= sp_r[i]; er_r[i+1] <= er_r[i];
      sx1_r[i+1] <= sx1_r[i]; sy1_r[i+1] <= sy1_r[i];
      rx0_r[i+1] <= rx0_r[i]; ry0_r[i+1] <= ry0_r[i];
    end
  end

  // ---------------- orientation and rotation pre-fold ----------------
  logic               o_v_r, o_err_r;
  logic [31:0]        o_ang_r;
  logic signed [VW-1:0] o_mp_r;
  logic signed [MW-1:0] o_mm_r;
  logic [SW-1:0]      o_sx_r, o_sy_r;
  logic signed [RW-1:0] o_rx_r, o_ry_r;
  logic signed [33:0] o_z_r;
  logic [31:0]        bang, orient;
  logic signed [33:0] zs;

  always_comb begin
    bang   = bzr_r[N] ? 32'd0 : bz_r[N];
    orient = sp_r[N] ? bang + QuarterTurn : bang - QuarterTurn;
    zs     = 34'($signed(orient));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= v1_r[N];
    end
    o_err_r <= er_r[N];
    o_ang_r <= orient;
    o_mp_r  <= pzr_r[N] ? '0 : qx_r[N];
    o_mm_r  <= mzr_r[N] ? '0 : mx_r[N];
    o_sx_r  <= sx1_r[N];
    o_sy_r  <= sy1_r[N];
    if (zs > 34'($signed({1'b0, QuarterTurn}))) begin
      o_rx_r <= -rx0_r[N]; o_ry_r <= -ry0_r[N];
      o_z_r  <= zs - 34'($signed({1'b0, HalfTurn}));
    end else if (zs < -34'($signed({1'b0, QuarterTurn}))) begin
      o_rx_r <= -rx0_r[N]; o_ry_r <= -ry0_r[N];
      o_z_r  <= zs + 34'($signed({1'b0, HalfTurn}));
    end else begin
      o_rx_r <= rx0_r[N]; o_ry_r <= ry0_r[N];
      o_z_r  <= zs;
    end
  end

  // ---------------- rotation chain ----------------
  logic signed [RW-1:0] rx_r [N+1], ry_r [N+1];
  logic signed [33:0]   rzc_r [N+1];
  logic                 v2_r [N+1], e2_r [N+1];
  logic [31:0]          a2_r [N+1];
  logic signed [VW-1:0] mp2_r [N+1];
  logic signed [MW-1:0] mm2_r [N+1];
  logic [SW-1:0]        sx2_r [N+1], sy2_r [N+1];

  always_comb begin
    rx_r[0] = o_rx_r; ry_r[0] = o_ry_r; rzc_r[0] = o_z_r;
    v2_r[0] = o_v_r; e2_r[0] = o_err_r; a2_r[0] = o_ang_r;
    mp2_r[0] = o_mp_r; mm2_r[0] = o_mm_r; sx2_r[0] = o_sx_r; sy2_r[0] = o_sy_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v2_r[i+1] <= 1'b0;
      end else begin
        v2_r[i+1] <= v2_r[i];
      end
      if (rzc_r[i] >= 0) begin
        rx_r[i+1]  <= rx_r[i] - (ry_r[i] >>> i);
        ry_r[i+1]  <= ry_r[i] + (rx_r[i] >>> i);
        rzc_r[i+1] <= rzc_r[i] - 34'(arc_tab(i));
      end else begin
        rx_r[i+1]  <= rx_r[i] + (ry_r[i] >>> i);
        ry_r[i+1]  <= ry_r[i] - (rx_r[i] >>> i);
        rzc_r[i+1] <= rzc_r[i] + 34'(arc_tab(i));
      end
      e2_r[i+1] <= e2_r[i]; a2_r[i+1] <= a2_r[i];
      mp2_r[i+1] <= mp2_r[i]; mm2_r[i+1] <= mm2_r[i];
      sx2_r[i+1] <= sx2_r[i]; sy2_r[i+1] <= sy2_r[i];
    end
  end

  // ---------------- gain compensation ----------------
  localparam int GW = RW + 32;
  logic               g_v_r, g_e_r;
  logic [31:0]        g_a_r;
  logic signed [VW-1:0] g_mp_r;
  logic signed [MW-1:0] g_mm_r;
  logic [SW-1:0]      g_sx_r, g_sy_r;
  logic signed [GW-1:0] g_px_r, g_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else begin
      g_v_r <= v2_r[N];
    end
    g_e_r <= e2_r[N]; g_a_r <= a2_r[N];
    g_mp_r <= mp2_r[N]; g_mm_r <= mm2_r[N];
    g_sx_r <= sx2_r[N]; g_sy_r <= sy2_r[N];
    g_px_r <= GW'(rx_r[N]) * GW'(InvGainQ30);
    g_py_r <= GW'(ry_r[N]) * GW'(InvGainQ30);
  end

  // round to Q.16
  localparam int QW = GW - 38 + 1;
  logic signed [GW-1:0] rnx, rny;
  logic signed [QW-1:0] qvx, qvy;
  always_comb begin
    rnx = g_px_r + (GW'(1) <<< 37);
    rny = g_py_r + (GW'(1) <<< 37);
    qvx = QW'(rnx >>> 38);
    qvy = QW'(rny >>> 38);
  end

  // numerator 16*mag_px*rv, over two stages: operands registered, then the x and y products
  localparam int NW = VW + QW + 5;
  logic               n_v_r, n_e_r;
  logic [31:0]        n_a_r;
  logic signed [MW-1:0] n_mm_r;
  logic [SW-1:0]      n_sx_r, n_sy_r;
  logic signed [VW-1:0] n_mp_r;
  logic signed [QW-1:0] n_qx_r, n_qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else begin
      n_v_r <= g_v_r;
    end
    n_e_r <= g_e_r; n_a_r <= g_a_r; n_mm_r <= g_mm_r;
    n_sx_r <= g_sx_r; n_sy_r <= g_sy_r;
    n_mp_r <= g_mp_r; n_qx_r <= qvx; n_qy_r <= qvy;
  end

  logic               p_v_r, p_e_r;
  logic [31:0]        p_a_r;
  logic [MW-1:0]      p_den_r;
  logic [SW-1:0]      p_sx_r, p_sy_r;
  logic signed [NW-1:0] p_nx_r, p_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= n_v_r;
    end
    p_e_r <= n_e_r; p_a_r <= n_a_r; p_sx_r <= n_sx_r; p_sy_r <= n_sy_r;
    p_den_r <= MW'(n_mm_r);
    p_nx_r <= (NW'(n_mp_r) * NW'(n_qx_r)) <<< 4;
    p_ny_r <= (NW'(n_mp_r) * NW'(n_qy_r)) <<< 4;
  end

  // ---------------- restoring dividers, one quotient bit a stage ----------------
  // divides |num| + 3*den/2 ... computed as (a + d/2)/d with d = 3*den
  localparam int DW = MW + 2;
  localparam int AW = NW;
  logic [AW-1:0] dvx_q [AW+1], dvy_q [AW+1];
  logic [DW:0]   dvx_rm [AW+1], dvy_rm [AW+1];
  logic [AW-1:0] dvx_n [AW+1], dvy_n [AW+1];
  logic [DW-1:0] dv_d [AW+1];
  logic          dv_v [AW+1], dv_e [AW+1], dvx_s [AW+1], dvy_s [AW+1];
  logic [31:0]   dv_a [AW+1];
  logic [SW-1:0] dv_sx [AW+1], dv_sy [AW+1];

  logic [DW-1:0] d3;
  logic [AW-1:0] ax, ay;
  always_comb begin
    d3 = DW'(p_den_r) * DW'(3);
    ax = (p_nx_r < 0) ? AW'(-p_nx_r) : AW'(p_nx_r);
    ay = (p_ny_r < 0) ? AW'(-p_ny_r) : AW'(p_ny_r);
    dvx_n[0] = ax + AW'(d3 >> 1);
    dvy_n[0] = ay + AW'(d3 >> 1);
    dvx_q[0] = '0; dvy_q[0] = '0; dvx_rm[0] = '0; dvy_rm[0] = '0;
    dv_d[0] = (d3 == '0) ? DW'(1) : d3;
    dv_v[0] = p_v_r; dv_e[0] = p_e_r; dv_a[0] = p_a_r;
    dvx_s[0] = p_nx_r < 0; dvy_s[0] = p_ny_r < 0;
    dv_sx[0] = p_sx_r; dv_sy[0] = p_sy_r;
  end

  for (genvar k = 0; k < AW; k++) begin : g_div
    logic [DW:0] tx, ty;
    always_comb begin
      tx = {dvx_rm[k][DW-1:0], dvx_n[k][AW-1-k]};
      ty = {dvy_rm[k][DW-1:0], dvy_n[k][AW-1-k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
      if (tx >= {1'b0, dv_d[k]}) begin
        dvx_rm[k+1] <= tx - {1'b0, dv_d[k]};
        dvx_q[k+1]  <= {dvx_q[k][AW-2:0], 1'b1};
      end else begin
        dvx_rm[k+1] <= tx;
        dvx_q[k+1]  <= {dvx_q[k][AW-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv_d[k]}) begin
        dvy_rm[k+1] <= ty - {1'b0, dv_d[k]};
        dvy_q[k+1]  <= {dvy_q[k][AW-2:0], 1'b1};
      end else begin
        dvy_rm[k+1] <= ty;
        dvy_q[k+1]  <= {dvy_q[k][AW-2:0], 1'b0};
      end
      dvx_n[k+1] <= dvx_n[k]; dvy_n[k+1] <= dvy_n[k];
      dv_d[k+1] <= dv_d[k]; dv_e[k+1] <= dv_e[k]; dv_a[k+1] <= dv_a[k];
      dvx_s[k+1] <= dvx_s[k]; dvy_s[k+1] <= dvy_s[k];
      dv_sx[k+1] <= dv_sx[k]; dv_sy[k+1] <= dv_sy[k];
    end
  end

  // ---------------- mean, difference, saturation ----------------
  // 16*sum/3 rounded: small, a constant divide handled by synthesis as reciprocal
  localparam int CW = AW + 2;
  logic [SW-1:0]       mxu, myu;
  logic signed [CW-1:0] cxw, cyw, corx, cory;
  logic [31:0]         hsum;
  always_comb begin
    mxu  = (dv_sx[AW] + SW'(1)) / SW'(3);
    myu  = (dv_sy[AW] + SW'(1)) / SW'(3);
    corx = dvx_s[AW] ? -CW'(dvx_q[AW]) : CW'(dvx_q[AW]);
    cory = dvy_s[AW] ? -CW'(dvy_q[AW]) : CW'(dvy_q[AW]);
    cxw  = CW'(mxu) - corx;
    cyw  = CW'(myu) - cory;
    hsum = dv_a[AW] + QuarterTurn + 32'h8000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= dv_v[AW];
    end
    err_o <= dv_e[AW];
    if (dv_e[AW]) begin
      cx_o <= '0; cy_o <= '0; hd_o <= '0;
    end else begin
      cx_o <= (cxw > CW'(SatHi)) ? SatHi : (cxw < CW'(SatLo)) ? SatLo : cxw[17:0];
      cy_o <= (cyw > CW'(SatHi)) ? SatHi : (cyw < CW'(SatLo)) ? SatLo : cyw[17:0];
      hd_o <= hsum[31:16];
    end
  end

endmodule

### src/three_marker_pose_estimate.sv
// Pose from three marker positions: one transaction enters per clock whenever
// start is high, busy is always low, and each result appears on out_valid for
// one cycle, after the vectoring and rotation CORDIC chains and the pipelined
// restoring dividers. The receiver cannot stall; results are never held.
module three_marker_pose_estimate import tmpe_pkg::*; #(
  parameter int PIXEL_BITS   = PixelBitsDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [PIXEL_BITS-1:0]  in_top_px_x,
  input  logic [PIXEL_BITS-1:0]  in_top_px_y,
  input  logic [PIXEL_BITS-1:0]  in_base_a_px_x,
  input  logic [PIXEL_BITS-1:0]  in_base_a_px_y,
  input  logic [PIXEL_BITS-1:0]  in_base_b_px_x,
  input  logic [PIXEL_BITS-1:0]  in_base_b_px_y,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [19:0]            cfg_data,
  output logic                   out_valid,
  output logic signed [17:0]     out_centre_x,
  output logic signed [17:0]     out_centre_y,
  output logic [15:0]            out_heading,
  output logic                   out_layout_error
);

  logic signed [19:0] lay_r [6];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // layout register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) lay_r[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_A_X:   lay_r[REG_A_X]   <= cfg_data;
        REG_A_Y:   lay_r[REG_A_Y]   <= cfg_data;
        REG_B_X:   lay_r[REG_B_X]   <= cfg_data;
        REG_B_Y:   lay_r[REG_B_Y]   <= cfg_data;
        REG_TOP_X: lay_r[REG_TOP_X] <= cfg_data;
        REG_TOP_Y: lay_r[REG_TOP_Y] <= cfg_data;
        default: ;
      endcase
    end
  end

  tmpe_datapath #(
    .PIXEL_BITS  (PIXEL_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (start & ~busy),
    .x1_i  (in_top_px_x),
    .y1_i  (in_top_px_y),
    .x2_i  (in_base_a_px_x),
    .y2_i  (in_base_a_px_y),
    .x3_i  (in_base_b_px_x),
    .y3_i  (in_base_b_px_y),
    .lay_i (lay_r),
    .vld_o (out_valid),
    .cx_o  (out_centre_x),
    .cy_o  (out_centre_y),
    .hd_o  (out_heading),
    .err_o (out_layout_error)
  );

endmodule

### src/tmpe_checker.sv
// port-level checks
module tmpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_layout_error,
  input logic [17:0] out_centre_x,
  input logic [15:0] out_heading
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layout_error |-> out_centre_x == 18'd0 && out_heading == 16'd0)
    else $error("error result not zeroed");

  a_no_valid_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind three_marker_pose_estimate tmpe_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .cfg_ready(cfg_ready),
  .out_valid(out_valid), .out_layout_error(out_layout_error),
  .out_centre_x(out_centre_x), .out_heading(out_heading)
);

### test/tb_top.sv
`timescale 1ns / 100ps

import tmpe_pkg::*;

typedef struct packed {
  logic signed [17:0] centre_x;
  logic signed [17:0] centre_y;
  logic [15:0]        heading;
  logic               layout_error;
} pose_t;

// predicts poses from marker triples and checks them in order
class pose_scoreboard;
  longint layout[6];
  pose_t  pending_poses[$];
  int     errors;
  int     checked;
  int     error_poses;

  localparam int Steps = 16;
  localparam longint InvGain = 652032874;

  function new();
    foreach (layout[i]) layout[i] = 0;
    errors = 0;
    checked = 0;
    error_poses = 0;
  endfunction

  function void set_layout(int idx, logic [19:0] value);
    if (idx < 6) layout[idx] = longint'(signed'(value));
  endfunction

  function bit [31:0] arc(int i);
    bit [31:0] atan_steps[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};
    return atan_steps[i];
  endfunction

  // angle and gain-scaled magnitude of a vector
  function void polar(longint x, longint y, output bit [31:0] ang, output longint mag);
    bit [31:0] z;
    longint nx, ny;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HalfTurn;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + arc(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - arc(i);
      end
      x = nx;
      y = ny;
    end
    ang = z;
    mag = x;
  endfunction

  // rotate a Q.16 vector by a binary angle
  function void turn(longint x, longint y, bit [31:0] ang, output longint rx,
                     output longint ry);
    longint z, nx, ny;
    z = (ang >= HalfTurn) ? longint'(ang) - 64'sd4294967296 : longint'(ang);
    x = x * 256;
    y = y * 256;
    if (z > longint'(QuarterTurn)) begin
      x = -x;
      y = -y;
      z = z - longint'(HalfTurn);
    end else if (z < -longint'(QuarterTurn)) begin
      x = -x;
      y = -y;
      z = z + longint'(HalfTurn);
    end
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - longint'(arc(i));
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + longint'(arc(i));
      end
      x = nx;
      y = ny;
    end
    rx = (x * InvGain + (64'sd1 <<< 37)) >>> 38;
    ry = (y * InvGain + (64'sd1 <<< 37)) >>> 38;
  endfunction

  // divide rounding halves away from zero, positive divisor
  function longint round_div(longint n, longint d);
    longint a, q;
    a = (n < 0) ? -n : n;
    q = (a + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function logic signed [17:0] clamp18(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return v[17:0];
  endfunction

  // note an accepted marker triple and predict its pose
  function void note_triple(logic [11:0] tx, logic [11:0] ty, logic [11:0] ax,
                            logic [11:0] ay, logic [11:0] bx, logic [11:0] by);
    longint x1, y1, x2, y2, x3, y3, mx2, my2, dx, dy, side;
    longint mag_px, mag_m, rvx, rvy, cx, cy;
    bit [31:0] base_ang, orient, spare;
    pose_t p;
    x1 = tx; y1 = ty; x2 = ax; y2 = ay; x3 = bx; y3 = by;
    mx2 = 2 * layout[4] - (layout[0] + layout[2]);
    my2 = 2 * layout[5] - (layout[1] + layout[3]);
    p = '0;
    if (mx2 == 0 && my2 == 0) begin
      p.layout_error = 1'b1;
      error_poses++;
      pending_poses.push_back(p);
      return;
    end
    dx = x3 - x2;
    dy = y3 - y2;
    side = dx * (y1 - y2) - dy * (x1 - x2);
    polar(dx, dy, base_ang, mag_px);
    orient = (side > 0) ? base_ang + QuarterTurn : base_ang - QuarterTurn;
    polar(2 * x1 - (x2 + x3), 2 * y1 - (y2 + y3), spare, mag_px);
    polar(mx2, my2, spare, mag_m);
    turn(layout[0] + layout[2] + layout[4], -(layout[1] + layout[3] + layout[5]),
         orient, rvx, rvy);
    cx = round_div(16 * (x1 + x2 + x3), 3) - round_div(mag_px * rvx * 16, 3 * mag_m);
    cy = round_div(16 * (y1 + y2 + y3), 3) - round_div(mag_px * rvy * 16, 3 * mag_m);
    p.centre_x = clamp18(cx);
    p.centre_y = clamp18(cy);
    p.heading = 16'((orient + QuarterTurn + 32'h8000) >> 16);
    pending_poses.push_back(p);
  endfunction

  // compare one result against the oldest prediction
  function void check_pose(pose_t got);
    pose_t exp_p;
    if (pending_poses.size() == 0) begin
      $error("unexpected result transaction");
      errors++;
      return;
    end
    exp_p = pending_poses.pop_front();
    checked++;
    if (got.centre_x !== exp_p.centre_x) begin
      $error("centre_x expected %0d got %0d", exp_p.centre_x, got.centre_x);
      errors++;
    end
    if (got.centre_y !== exp_p.centre_y) begin
      $error("centre_y expected %0d got %0d", exp_p.centre_y, got.centre_y);
      errors++;
    end
    if (got.heading !== exp_p.heading) begin
      $error("heading expected %0d got %0d", exp_p.heading, got.heading);
      errors++;
    end
    if (got.layout_error !== exp_p.layout_error) begin
      $error("layout_error expected %0d got %0d", exp_p.layout_error, got.layout_error);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int Drain = 400;
  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_top_px_x = '0, in_top_px_y = '0;
  logic [11:0] in_base_a_px_x = '0, in_base_a_px_y = '0;
  logic [11:0] in_base_b_px_x = '0, in_base_b_px_y = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        out_valid;
  logic signed [17:0] out_centre_x, out_centre_y;
  logic [15:0] out_heading;
  logic        out_layout_error;

  pose_scoreboard sb = new();
  int sent = 0;
  int idle_pct = 0;
  int cycles = 0;

  three_marker_pose_estimate u_top (
    .clk, .rst_n, .start, .busy,
    .in_top_px_x, .in_top_px_y, .in_base_a_px_x, .in_base_a_px_y,
    .in_base_b_px_x, .in_base_b_px_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_centre_x, .out_centre_y, .out_heading, .out_layout_error
  );

  always #5 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_pose({out_centre_x, out_centre_y, out_heading, out_layout_error});
  end

  // send one marker triple, with random idle cycles ahead of it
  task automatic send_triple(logic [11:0] tx, logic [11:0] ty, logic [11:0] ax,
                             logic [11:0] ay, logic [11:0] bx, logic [11:0] by);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_top_px_x <= 12'($urandom);
      in_base_b_px_y <= 12'($urandom);
      @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_top_px_x <= tx; in_top_px_y <= ty;
    in_base_a_px_x <= ax; in_base_a_px_y <= ay;
    in_base_b_px_x <= bx; in_base_b_px_y <= by;
    do @(posedge clk); while (busy);
    sb.note_triple(tx, ty, ax, ay, bx, by);
    sent++;
  endtask

  task automatic send_random();
    logic [11:0] v[6];
    foreach (v[i]) v[i] = 12'($urandom);
    // occasionally coincident base markers or top on the base line
    case ($urandom_range(15))
      0: begin v[4] = v[2]; v[5] = v[3]; end
      1: begin v[0] = v[2]; v[1] = v[3]; end
      default: ;
    endcase
    send_triple(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  // stop sending until every prediction is matched, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_layout(logic [19:0] vals[6]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= (i < 6) ? vals[i] : 20'($urandom);
      do @(posedge clk); while (!cfg_ready);
      sb.set_layout(i, (i < 6) ? vals[i] : 20'h0);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [19:0] lay[6];
    int pcts[4] = '{0, 58, 0, 35};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset layout is degenerate: every pose flags the error
    send_triple(12'd100, 12'd200, 12'd300, 12'd400, 12'd500, 12'd600);
    send_triple(12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'd0);
    wait_idle();

    // directed: plausible layout, extreme and degenerate marker positions
    lay = '{-20'sd6554, 20'sd0, 20'sd6554, 20'sd0, 20'sd0, 20'sd13107};
    write_layout(lay);
    send_triple(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_triple(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_triple(12'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0);
    send_triple(12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF);
    send_triple(12'd50, 12'd50, 12'd100, 12'd100, 12'd100, 12'd100);
    send_triple(12'd200, 12'd200, 12'd100, 12'd100, 12'd300, 12'd300);
    send_triple(12'd200, 12'd100, 12'd100, 12'd100, 12'd300, 12'd100);
    send_triple(12'd200, 12'd300, 12'd100, 12'd100, 12'd300, 12'd100);
    send_triple(12'd200, 12'd300, 12'd300, 12'd100, 12'd100, 12'd100);
    send_triple(12'd100, 12'd200, 12'd100, 12'd300, 12'd100, 12'd100);
    send_triple(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h0F0, 12'hF0F);
    send_triple(12'hFFF, 12'h000, 12'd0, 12'hFFF, 12'd1, 12'hFFE);
    wait_idle();

    // random phases over several layouts, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lay = '{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000};
        1: lay = '{20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF};
        2: lay = '{20'h00010, 20'hFFFF0, 20'h00020, 20'h00030, 20'h00018, 20'hFFFF8};
        default: foreach (lay[i]) lay[i] = 20'($urandom);
      endcase
      write_layout(lay);
      idle_pct = pcts[ph % 4];
      repeat (160) send_random();
      wait_idle();
    end

    // degenerate layout written mid-run: top at base midpoint
    lay = '{20'd1000, 20'd2000, 20'd3000, 20'hFF000, 20'd2000, 20'h7F3E8};
    lay[5] = 20'((20'd2000 + 20'hFF000) >>> 1);
    lay[5] = {lay[5][18], lay[5][18:0]};
    write_layout(lay);
    idle_pct = 35;
    repeat (20) send_random();
    wait_idle();

    $display("covered %0d marker triples over 9 layouts, %0d results checked, %0d flagged",
             sent, sb.checked, sb.error_poses);
    if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

### sim.f
src/tmpe_pkg.sv
src/tmpe_datapath.sv
src/three_marker_pose_estimate.sv
src/tmpe_checker.sv
test/tb_top.sv
